[rtl/core/battery_fuel_gauge_defines.svh]
// Assertion macros shared by the fuel gauge RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef BATTERY_FUEL_GAUGE_DEFINES_SVH
`define BATTERY_FUEL_GAUGE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define BFG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define BFG_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/core/bfg_pkg.sv]
// Shared types, constants and curve tables of the fuel gauge.
// Depends on nothing; used by every module of the block.
package bfg_pkg;

  localparam int PIN_W    = 12;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 7;
  localparam int RATIO_W  = 4;
  localparam int CFG_IDX_W = 2;

  // Group length is a power of two so the mean is a plain shift.
  localparam int SPP_LOG2         = 3;
  localparam int SAMPLES_PER_POLL = 1 << SPP_LOG2;
  localparam int SUM_W            = PIN_W + SPP_LOG2;
  localparam int CNT_W            = (SPP_LOG2 > 0) ? SPP_LOG2 : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = QPTR_W + 1;

  // Segment math: quotient = (n * recip) >> RECIP_SHIFT.
  localparam int SEG_W       = 3;
  localparam int DIFF_W      = 9;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = DIFF_W + RECIP_W;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd3;
  localparam logic [MV_W-1:0]    HIGH_RESET  = 16'd4160;
  localparam logic [MV_W-1:0]    LOW_RESET   = 16'd4120;
  localparam logic [MV_W-1:0]    CURVE_LO_MV = 16'd3000;
  localparam logic [MV_W-1:0]    CURVE_HI_MV = 16'd4200;
  localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]   PCT_EMPTY   = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVIDER  = 2'd0,
    CFG_EXT_HIGH = 2'd1,
    CFG_EXT_LOW  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [MV_W-1:0]    ext_high;
    logic [MV_W-1:0]    ext_low;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Curve breakpoints in mV, by segment start.
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] v;
    case (idx)
      3'd0:    v = 16'd3000;
      3'd1:    v = 16'd3300;
      3'd2:    v = 16'd3500;
      3'd3:    v = 16'd3700;
      3'd4:    v = 16'd3800;
      3'd5:    v = 16'd3900;
      3'd6:    v = 16'd4000;
      3'd7:    v = 16'd4100;
      default: v = 16'd3000;
    endcase
    return v;
  endfunction

  // Percent at each segment start.
  function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
    logic [PCT_W-1:0] v;
    case (idx)
      3'd0:    v = 7'd0;
      3'd1:    v = 7'd5;
      3'd2:    v = 7'd10;
      3'd3:    v = 7'd35;
      3'd4:    v = 7'd50;
      3'd5:    v = 7'd65;
      3'd6:    v = 7'd80;
      3'd7:    v = 7'd90;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // rise/span reduced: 1/60, 1/40, 1/8, 3/20 (x3), 1/10 (x2). Numerator 3 flagged here.
  function automatic logic seg_triple(input logic [SEG_W-1:0] idx);
    return (idx == 3'd3) || (idx == 3'd4) || (idx == 3'd5);
  endfunction

  // ceil(2^16 / divisor); exact floor for the small numerators seen here.
  function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] idx);
    logic [RECIP_W-1:0] v;
    case (idx)
      3'd0:    v = 14'd1093;
      3'd1:    v = 14'd1639;
      3'd2:    v = 14'd8192;
      3'd3:    v = 14'd3277;
      3'd4:    v = 14'd3277;
      3'd5:    v = 14'd3277;
      3'd6:    v = 14'd6554;
      3'd7:    v = 14'd6554;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/bfg_front.sv]
// Front end: accepts ADC samples and sums them into groups.
// Depends on bfg_pkg; pushes each finished group sum into bfg_queue.
module bfg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bfg_pkg::PIN_W-1:0] pin_mv_i,
  input  bfg_pkg::q_status_t        q_status_i,
  output logic                      push_o,
  output logic [bfg_pkg::SUM_W-1:0] push_sum_o
);
  import bfg_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             accept;
  logic             last;
  logic [SUM_W-1:0] sum_total;

  // Hold off samples while the queue has no room.
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign last       = (count_q == CNT_W'(SAMPLES_PER_POLL - 1));
  assign sum_total  = sum_q + SUM_W'(pin_mv_i);

  // Accumulate; close the group on its last sample.
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (accept) begin
      if (last) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_total;
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  assign push_o     = accept && last;
  assign push_sum_o = sum_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

[rtl/core/bfg_queue.sv]
// Short FIFO of group sums between front and back end.
// Depends on bfg_pkg and battery_fuel_gauge_defines.svh.
`include "battery_fuel_gauge_defines.svh"
module bfg_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic [bfg_pkg::SUM_W-1:0] push_sum_i,
  input  logic                      pop_i,
  output logic [bfg_pkg::SUM_W-1:0] pop_sum_o,
  output bfg_pkg::q_status_t        status_o
);
  import bfg_pkg::*;

  logic [SUM_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_sum_o      = mem_q[rd_ptr_q];

  // Advance pointers and occupancy.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; no reset on payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_sum_i;
    end
  end

  `BFG_NEVER(a_no_overflow, push_i && status_o.full && !pop_i, "queue push while full")
  `BFG_NEVER(a_no_underflow, pop_i && status_o.empty, "queue pop while empty")

endmodule

[rtl/core/bfg_back.sv]
// Back end: pack voltage, EMA, hysteresis flag and charge curve.
// Depends on bfg_pkg and battery_fuel_gauge_defines.svh; fed by bfg_queue.
`include "battery_fuel_gauge_defines.svh"
module bfg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bfg_pkg::cfg_t             cfg_i,
  input  bfg_pkg::q_status_t        q_status_i,
  input  logic [bfg_pkg::SUM_W-1:0] pop_sum_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bfg_pkg::MV_W-1:0]  rail_mv_o,
  output logic [bfg_pkg::PCT_W-1:0] charge_percent_o,
  output logic                      on_external_o
);
  import bfg_pkg::*;

  logic               en;
  // Stage 1: pack voltage
  logic               v1_q;
  logic [MV_W-1:0]    pack_q;
  logic [PIN_W-1:0]   mean;
  logic [MV_W-1:0]    pack_d;
  // Stage 2: smoothing state
  logic               v2_q;
  logic [MV_W-1:0]    smooth_q, smooth_d;
  logic               primed_q;
  logic [MV_W+1:0]    ema_sum;
  // Stage 3: curve setup and flag
  logic               v3_q;
  logic               flag_q, flag_d;
  logic [MV_W-1:0]    rail3_q;
  logic               lo_q, hi_q;
  logic [PCT_W-1:0]   base_q;
  logic [DIFF_W-1:0]  num_q;
  logic [RECIP_W-1:0] recip_q;
  logic [SEG_W-1:0]   seg;
  logic [MV_W-1:0]    diff16;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W:0]    num_wide;
  // Stage 4: output register
  logic               v4_q;
  logic [MV_W-1:0]    rail4_q;
  logic [PCT_W-1:0]   pct4_q, pct4_d;
  logic               ext4_q;
  logic [PROD_W-1:0]  prod;

  // Advance the whole pipe unless a result waits on a stalled sink.
  assign en    = !v4_q || !out_stall_i;
  assign pop_o = en && !q_status_i.empty;

  // Mean by shift, then scale by the divider ratio.
  assign mean   = pop_sum_i[SUM_W-1:SPP_LOG2];
  assign pack_d = MV_W'(mean) * MV_W'(cfg_i.ratio);

  // EMA: (3*old + pack) / 4, or load on the first group.
  assign ema_sum  = {2'b00, smooth_q} + {1'b0, smooth_q, 1'b0} + {2'b00, pack_q};
  assign smooth_d = primed_q ? ema_sum[MV_W+1:2] : pack_q;

  // Locate the curve segment and form the scaled numerator.
  always_comb begin
    seg = '0;
    for (int k = 1; k < 8; k++) begin
      if (smooth_q >= curve_mv(SEG_W'(k))) begin
        seg = SEG_W'(k);
      end
    end
  end
  assign diff16   = smooth_q - curve_mv(seg);
  assign diff     = diff16[DIFF_W-1:0];
  assign num_wide = seg_triple(seg) ? ({diff, 1'b0} + {1'b0, diff}) : {1'b0, diff};

  // Set at or above high, otherwise clear at or below low.
  always_comb begin
    flag_d = flag_q;
    if (smooth_q >= cfg_i.ext_high) begin
      flag_d = 1'b1;
    end else if (smooth_q <= cfg_i.ext_low) begin
      flag_d = 1'b0;
    end
  end

  // Interpolate and clamp the percentage.
  assign prod = PROD_W'(num_q) * PROD_W'(recip_q);
  always_comb begin
    if (lo_q) begin
      pct4_d = PCT_EMPTY;
    end else if (hi_q) begin
      pct4_d = PCT_FULL;
    end else begin
      pct4_d = base_q + prod[PROD_W-1:RECIP_SHIFT];
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      smooth_q <= '0;
      primed_q <= 1'b0;
      flag_q   <= 1'b1;
    end else if (en) begin
      v1_q <= !q_status_i.empty;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (v1_q) begin
        smooth_q <= smooth_d;
        primed_q <= 1'b1;
      end
      if (v2_q) begin
        flag_q <= flag_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pack_q  <= pack_d;
      rail3_q <= smooth_q;
      lo_q    <= (smooth_q <= CURVE_LO_MV);
      hi_q    <= (smooth_q >= CURVE_HI_MV);
      base_q  <= curve_pct(seg);
      num_q   <= num_wide[DIFF_W-1:0];
      recip_q <= seg_recip(seg);
      rail4_q <= rail3_q;
      pct4_q  <= pct4_d;
      ext4_q  <= flag_q;
    end
  end

  assign out_valid_o      = v4_q;
  assign rail_mv_o        = rail4_q;
  assign charge_percent_o = pct4_q;
  assign on_external_o    = ext4_q;

  `BFG_NEVER(a_primed_sticks, $fell(primed_q), "primed dropped after first group")
  `BFG_ASSERT(a_primed_before_use, v2_q |-> primed_q, "smoothed value used before priming")
  `BFG_ASSERT(a_pct_in_range, v4_q |-> (pct4_q <= PCT_FULL), "charge percent above full")

endmodule

[rtl/core/battery_fuel_gauge.sv]
// Top level of the voltage-based Li-ion fuel gauge.
// Depends on bfg_pkg, bfg_front, bfg_queue and bfg_back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  sample  | in        | in_valid_i / in_stall_o  | pin_mv_i
//  result  | out       | out_valid_o / out_stall_i| rail_mv_o, charge_percent_o, on_external_o
//  config  | in        | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One sample is accepted per cycle unless in_stall_o is high; every 8th sample closes a
// group and yields one result. That result passes through the queue and then the back-end
// stages: pack voltage, smoothing, curve setup and flag, output register.
// The 4-entry group queue keeps samples flowing while the output stalls, until it fills.
// Reset clears the sums, the average and priming, and sets the external flag.
// Configuration writes are always taken (cfg_ready_o is high).
module battery_fuel_gauge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bfg_pkg::PIN_W-1:0]     pin_mv_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bfg_pkg::MV_W-1:0]      rail_mv_o,
  output logic [bfg_pkg::PCT_W-1:0]     charge_percent_o,
  output logic                          on_external_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bfg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bfg_pkg::MV_W-1:0]      cfg_data_i
);
  import bfg_pkg::*;

  cfg_t             cfg_q;
  q_status_t        q_status;
  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic             pop;
  logic [SUM_W-1:0] pop_sum;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers; unknown indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio    <= RATIO_RESET;
      cfg_q.ext_high <= HIGH_RESET;
      cfg_q.ext_low  <= LOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_DIVIDER:  cfg_q.ratio    <= cfg_data_i[RATIO_W-1:0];
        CFG_EXT_HIGH: cfg_q.ext_high <= cfg_data_i;
        CFG_EXT_LOW:  cfg_q.ext_low  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  bfg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pin_mv_i   (pin_mv_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_sum_o (push_sum)
  );

  bfg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_sum_i (push_sum),
    .pop_i      (pop),
    .pop_sum_o  (pop_sum),
    .status_o   (q_status)
  );

  bfg_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .q_status_i       (q_status),
    .pop_sum_i        (pop_sum),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rail_mv_o        (rail_mv_o),
    .charge_percent_o (charge_percent_o),
    .on_external_o    (on_external_o)
  );

endmodule
